// ===== rtl/sha256_byte_stream_hasher_unit_defines.svh =====
// assertion macros for the sha-256 byte stream hasher
// no dependencies; included by the top level

`ifndef SHA256_BYTE_STREAM_HASHER_UNIT_DEFINES_SVH
`define SHA256_BYTE_STREAM_HASHER_UNIT_DEFINES_SVH

// same-cycle implication, checked outside reset
`define SHA_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, checked outside reset
`define SHA_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/sha256_pkg.sv =====
// sha-256 constants, round table and word functions
// no dependencies; used by sha256_byte_stream_hasher_unit

package sha256_pkg;

  typedef logic [31:0] word_t;

  localparam word_t INIT_HASH [8] = '{
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
  };

  localparam word_t ROUND_K [64] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
    32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
    32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
    32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
    32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
    32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
    32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
    32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
    32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
    32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
    32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };

  localparam logic [7:0] PAD_BYTE  = 8'h80;
  localparam logic [7:0] ZERO_BYTE = 8'h00;
  localparam logic [5:0] LEN_POS   = 6'd56;
  localparam logic [5:0] LAST_POS  = 6'd63;
  localparam logic [5:0] LAST_RND  = 6'd63;
  localparam logic [2:0] LAST_IDX  = 3'd7;

  function automatic word_t rotr(word_t x, int unsigned n);
    return (x >> n) | (x << (32 - n));
  endfunction

  function automatic word_t big_sigma0(word_t x);
    return rotr(x, 2) ^ rotr(x, 13) ^ rotr(x, 22);
  endfunction

  function automatic word_t big_sigma1(word_t x);
    return rotr(x, 6) ^ rotr(x, 11) ^ rotr(x, 25);
  endfunction

  function automatic word_t small_sigma0(word_t x);
    return rotr(x, 7) ^ rotr(x, 18) ^ (x >> 3);
  endfunction

  function automatic word_t small_sigma1(word_t x);
    return rotr(x, 17) ^ rotr(x, 19) ^ (x >> 10);
  endfunction

  function automatic word_t choose(word_t x, word_t y, word_t z);
    return (x & y) ^ (~x & z);
  endfunction

  function automatic word_t majority(word_t x, word_t y, word_t z);
    return (x & y) ^ (x & z) ^ (y & z);
  endfunction

endpackage

// ===== rtl/sha256_byte_stream_hasher_unit.sv =====
// SHA-256 over a byte stream, one absorb or finish transaction at a time. An absorb
// of the byte that fills the 64-byte block starts a compression: 64 rounds through the
// single round unit, then a fold state that adds into the chaining words; other absorbs
// do not stall the input. A finish writes padding and the big-endian bit length one
// byte per cycle (up to 64 bytes per block), runs one or two compressions, then presents
// the eight digest words, word 0 first, as eight output transactions; the block stalls
// its input from the finish until the last word is taken, then starts a new message.
// depends on sha256_pkg and sha256_byte_stream_hasher_unit_defines.svh

`include "sha256_byte_stream_hasher_unit_defines.svh"

module sha256_byte_stream_hasher_unit (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic               in_func,
  input  logic [7:0]         in_data_byte,
  output logic               out_valid,
  input  logic               out_stall,
  output sha256_pkg::word_t  out_digest_word,
  output logic [2:0]         out_word_index,
  output logic               out_last_word
);
  import sha256_pkg::*;

  typedef enum logic [4:0] {
    S_IDLE  = 5'b00001,
    S_PAD   = 5'b00010,
    S_ROUND = 5'b00100,
    S_FOLD  = 5'b01000,
    S_OUT   = 5'b10000
  } state_t;

  state_t      state_r, state_nxt;
  word_t       chain_r [8];
  word_t       chain_nxt [8];
  word_t       v_r [8];
  word_t       v_nxt [8];
  word_t       w_r [16];
  word_t       w_nxt [16];
  logic [5:0]  fill_r, fill_nxt;
  logic [63:0] len_r, len_nxt;
  logic [5:0]  rnd_r, rnd_nxt;
  logic [2:0]  idx_r, idx_nxt;
  logic        finishing_r, finishing_nxt;
  logic        first_r, first_nxt;
  logic        two_r, two_nxt;

  logic        in_acc;
  logic        out_acc;
  logic        shift_en;
  logic [7:0]  shift_byte;
  logic        len_byte;
  word_t       t1;
  word_t       t2;
  word_t       w_new;

  assign in_stall        = (state_r != S_IDLE);
  assign in_acc          = in_valid && !in_stall;
  assign out_valid       = (state_r == S_OUT);
  assign out_acc         = out_valid && !out_stall;
  assign out_digest_word = chain_r[idx_r];
  assign out_word_index  = idx_r;
  assign out_last_word   = (idx_r == LAST_IDX);

  // round unit and schedule update
  assign t1 = v_r[7] + big_sigma1(v_r[4]) + choose(v_r[4], v_r[5], v_r[6])
            + ROUND_K[rnd_r] + w_r[0];
  assign t2 = big_sigma0(v_r[0]) + majority(v_r[0], v_r[1], v_r[2]);
  assign w_new = small_sigma1(w_r[14]) + w_r[9] + small_sigma0(w_r[1]) + w_r[0];

  assign len_byte = (fill_r >= LEN_POS) && !two_r;

  always_comb begin
    state_nxt     = state_r;
    chain_nxt     = chain_r;
    v_nxt         = v_r;
    fill_nxt      = fill_r;
    len_nxt       = len_r;
    rnd_nxt       = rnd_r;
    idx_nxt       = idx_r;
    finishing_nxt = finishing_r;
    first_nxt     = first_r;
    two_nxt       = two_r;
    shift_en      = 1'b0;
    shift_byte    = in_data_byte;

    unique case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          if (in_func) begin
            finishing_nxt = 1'b1;
            first_nxt     = 1'b1;
            two_nxt       = (fill_r >= LEN_POS);
            state_nxt     = S_PAD;
          end else begin
            shift_en = 1'b1;
            len_nxt  = len_r + 64'd8;
            fill_nxt = fill_r + 6'd1;
            if (fill_r == LAST_POS) begin
              v_nxt     = chain_r;
              rnd_nxt   = '0;
              state_nxt = S_ROUND;
            end
          end
        end
      end
      S_PAD: begin
        shift_en  = 1'b1;
        first_nxt = 1'b0;
        if (first_r) begin
          shift_byte = PAD_BYTE;
        end else if (len_byte) begin
          shift_byte = len_r[63:56];
          len_nxt    = {len_r[55:0], ZERO_BYTE};
        end else begin
          shift_byte = ZERO_BYTE;
        end
        fill_nxt = fill_r + 6'd1;
        if (fill_r == LAST_POS) begin
          v_nxt     = chain_r;
          rnd_nxt   = '0;
          state_nxt = S_ROUND;
        end
      end
      S_ROUND: begin
        v_nxt[7] = v_r[6];
        v_nxt[6] = v_r[5];
        v_nxt[5] = v_r[4];
        v_nxt[4] = v_r[3] + t1;
        v_nxt[3] = v_r[2];
        v_nxt[2] = v_r[1];
        v_nxt[1] = v_r[0];
        v_nxt[0] = t1 + t2;
        rnd_nxt  = rnd_r + 6'd1;
        if (rnd_r == LAST_RND) begin
          state_nxt = S_FOLD;
        end
      end
      S_FOLD: begin
        for (int i = 0; i < 8; i++) begin
          chain_nxt[i] = chain_r[i] + v_r[i];
        end
        priority if (!finishing_r) begin
          state_nxt = S_IDLE;
        end else if (two_r) begin
          two_nxt   = 1'b0;
          state_nxt = S_PAD;
        end else begin
          idx_nxt   = '0;
          state_nxt = S_OUT;
        end
      end
      S_OUT: begin
        if (out_acc) begin
          idx_nxt = idx_r + 3'd1;
          if (idx_r == LAST_IDX) begin
            chain_nxt     = INIT_HASH;
            len_nxt       = '0;
            fill_nxt      = '0;
            finishing_nxt = 1'b0;
            state_nxt     = S_IDLE;
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // block buffer doubles as the message schedule window
  always_comb begin
    w_nxt = w_r;
    if (shift_en) begin
      for (int i = 0; i < 15; i++) begin
        w_nxt[i] = {w_r[i][23:0], w_r[i + 1][31:24]};
      end
      w_nxt[15] = {w_r[15][23:0], shift_byte};
    end else if (state_r == S_ROUND) begin
      for (int i = 0; i < 15; i++) begin
        w_nxt[i] = w_r[i + 1];
      end
      w_nxt[15] = w_new;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      chain_r     <= INIT_HASH;
      fill_r      <= '0;
      len_r       <= '0;
      rnd_r       <= '0;
      idx_r       <= '0;
      finishing_r <= 1'b0;
      first_r     <= 1'b0;
      two_r       <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      chain_r     <= chain_nxt;
      fill_r      <= fill_nxt;
      len_r       <= len_nxt;
      rnd_r       <= rnd_nxt;
      idx_r       <= idx_nxt;
      finishing_r <= finishing_nxt;
      first_r     <= first_nxt;
      two_r       <= two_nxt;
    end
  end

  always_ff @(posedge clk) begin
    v_r <= v_nxt;
    w_r <= w_nxt;
  end

  `SHA_ASSERT_NOW(a_no_input_while_output, in_acc, !out_valid, "input taken during digest output")
  `SHA_ASSERT_NEXT(a_full_block_starts_rounds, in_acc && !in_func && (fill_r == LAST_POS), (state_r == S_ROUND) && (rnd_r == '0), "full block did not start compression")
  `SHA_ASSERT_NEXT(a_rounds_end_in_fold, (state_r == S_ROUND) && (rnd_r == LAST_RND), state_r == S_FOLD, "compression did not end after 64 rounds")
  `SHA_ASSERT_NEXT(a_last_word_returns_idle, out_acc && out_last_word, !in_stall && !out_valid && (fill_r == '0) && (len_r == '0), "state not cleared after digest")

endmodule

// ===== sim/tb.sv =====
// testbench for sha256_byte_stream_hasher_unit: message bytes in, digest words out
// carries its own sha-256 model and checks every digest word against it
// depends on sha256_pkg and the hasher rtl

module tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic FN_ABSORB = 1'b0;
  localparam logic FN_FINISH = 1'b1;
  localparam logic [7:0] PAD_MARK = 8'h80;
  localparam int TIMEOUT_NS = 400000 * 12;

  localparam sha256_pkg::word_t IV [8] = '{
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
  };

  localparam sha256_pkg::word_t KTAB [64] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5, 32'h3956c25b, 32'h59f111f1,
    32'h923f82a4, 32'hab1c5ed5, 32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174, 32'he49b69c1, 32'hefbe4786,
    32'h0fc19dc6, 32'h240ca1cc, 32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7, 32'hc6e00bf3, 32'hd5a79147,
    32'h06ca6351, 32'h14292967, 32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85, 32'ha2bfe8a1, 32'ha81a664b,
    32'hc24b8b70, 32'hc76c51a3, 32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5, 32'h391c0cb3, 32'h4ed8aa4a,
    32'h5b9cca4f, 32'h682e6ff3, 32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };

  typedef struct packed {
    logic       func;
    logic [7:0] data;
  } hash_cmd_t;

  typedef struct packed {
    sha256_pkg::word_t word;
    logic [2:0]        index;
    logic              last;
  } digest_item_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic in_func = 1'b0;
  logic [7:0] in_data_byte = 8'h00;
  logic out_valid;
  logic out_stall = 1'b0;
  sha256_pkg::word_t out_digest_word;
  logic [2:0] out_word_index;
  logic out_last_word;

  hash_cmd_t hash_cmds [$];
  digest_item_t expected_digest [$];
  digest_item_t want;
  hash_cmd_t next_cmd;
  int err_count = 0;
  int send_gap = 0;
  int recv_gap = 0;

  sha256_pkg::word_t chain [8];
  logic [7:0] blk [64];
  logic [5:0] fill;
  logic [63:0] msg_bits;

  sha256_byte_stream_hasher_unit DUT (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_func         (in_func),
    .in_data_byte    (in_data_byte),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_digest_word (out_digest_word),
    .out_word_index  (out_word_index),
    .out_last_word   (out_last_word)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  function automatic sha256_pkg::word_t rot_right(sha256_pkg::word_t x, int n);
    return (x >> n) | (x << (32 - n));
  endfunction

  function automatic void clear_hash_state();
    for (int i = 0; i < 8; i++) chain[i] = IV[i];
    for (int i = 0; i < 64; i++) blk[i] = 8'h00;
    fill = 6'd0;
    msg_bits = 64'd0;
  endfunction

  function automatic void compress_block();
    sha256_pkg::word_t w [64];
    sha256_pkg::word_t v [8];
    sha256_pkg::word_t s0, s1, t1, t2;
    for (int i = 0; i < 16; i++)
      w[i] = {blk[4*i], blk[4*i+1], blk[4*i+2], blk[4*i+3]};
    for (int i = 16; i < 64; i++) begin
      s0 = rot_right(w[i-15], 7) ^ rot_right(w[i-15], 18) ^ (w[i-15] >> 3);
      s1 = rot_right(w[i-2], 17) ^ rot_right(w[i-2], 19) ^ (w[i-2] >> 10);
      w[i] = s0 + w[i-16] + s1 + w[i-7];
    end
    for (int i = 0; i < 8; i++) v[i] = chain[i];
    for (int i = 0; i < 64; i++) begin
      t1 = v[7] + (rot_right(v[4], 6) ^ rot_right(v[4], 11) ^ rot_right(v[4], 25))
         + ((v[4] & v[5]) ^ (~v[4] & v[6])) + KTAB[i] + w[i];
      t2 = (rot_right(v[0], 2) ^ rot_right(v[0], 13) ^ rot_right(v[0], 22))
         + ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
      v[7] = v[6];
      v[6] = v[5];
      v[5] = v[4];
      v[4] = v[3] + t1;
      v[3] = v[2];
      v[2] = v[1];
      v[1] = v[0];
      v[0] = t1 + t2;
    end
    for (int i = 0; i < 8; i++) chain[i] = chain[i] + v[i];
  endfunction

  function automatic void hash_transaction(logic func, logic [7:0] data);
    int pos;
    digest_item_t item;
    if (func == FN_ABSORB) begin
      blk[fill] = data;
      msg_bits = msg_bits + 64'd8;
      fill = fill + 6'd1;
      if (fill == 6'd0) compress_block();
    end else begin
      pos = fill;
      blk[pos] = PAD_MARK;
      pos++;
      if (pos > 56) begin
        while (pos < 64) begin
          blk[pos] = 8'h00;
          pos++;
        end
        compress_block();
        pos = 0;
      end
      while (pos < 56) begin
        blk[pos] = 8'h00;
        pos++;
      end
      for (int i = 0; i < 8; i++) blk[56+i] = msg_bits[63-8*i -: 8];
      compress_block();
      for (int i = 0; i < 8; i++) begin
        item.word = chain[i];
        item.index = 3'(i);
        item.last = (i == 7);
        expected_digest = {expected_digest, item};
      end
      clear_hash_state();
    end
  endfunction

  function automatic void queue_cmd(logic func, logic [7:0] data);
    hash_cmd_t c;
    c.func = func;
    c.data = data;
    hash_cmds = {hash_cmds, c};
  endfunction

  function automatic void queue_message(int len);
    for (int i = 0; i < len; i++) queue_cmd(FN_ABSORB, 8'($urandom));
    queue_cmd(FN_FINISH, 8'($urandom));
  endfunction

  // driver
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) hash_transaction(in_func, in_data_byte);
      if (!in_valid || !in_stall) begin
        if (send_gap > 0) begin
          send_gap = send_gap - 1;
          in_valid <= 1'b0;
        end else if (hash_cmds.size() > 0) begin
          next_cmd = hash_cmds.pop_front();
          in_valid <= 1'b1;
          in_func <= next_cmd.func;
          in_data_byte <= next_cmd.data;
          if (hash_cmds.size() > 40 && $urandom_range(0, 5) == 0)
            send_gap = $urandom_range(1, 9);
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        if (expected_digest.size() == 0) begin
          $display("%0t: unexpected digest transaction, expected none, actual word %h idx %0d",
                   $time, out_digest_word, out_word_index);
          err_count++;
        end else begin
          want = expected_digest.pop_front();
          if (out_digest_word !== want.word) begin
            $display("%0t: digest_word expected %h actual %h", $time, want.word,
                     out_digest_word);
            err_count++;
          end
          if (out_word_index !== want.index) begin
            $display("%0t: word_index expected %0d actual %0d", $time, want.index,
                     out_word_index);
            err_count++;
          end
          if (out_last_word !== want.last) begin
            $display("%0t: last_word expected %0d actual %0d", $time, want.last,
                     out_last_word);
            err_count++;
          end
        end
      end
      if (recv_gap > 0) begin
        recv_gap = recv_gap - 1;
        out_stall <= 1'b1;
      end else begin
        out_stall <= 1'b0;
        if (hash_cmds.size() > 40 && $urandom_range(0, 5) == 0)
          recv_gap = $urandom_range(1, 9);
      end
    end
  end

  initial begin
    int edge_lens [$];
    clear_hash_state();

    // empty message, then "abc", then the byte extremes
    queue_cmd(FN_FINISH, 8'hff);
    queue_cmd(FN_ABSORB, 8'h61);
    queue_cmd(FN_ABSORB, 8'h62);
    queue_cmd(FN_ABSORB, 8'h63);
    queue_cmd(FN_FINISH, 8'h00);
    queue_cmd(FN_ABSORB, 8'h00);
    queue_cmd(FN_ABSORB, 8'hff);
    queue_cmd(FN_FINISH, 8'h5a);

    // block boundary lengths mixed among short messages and occasional 118 to 120 byte ones
    edge_lens = '{55, 56, 63, 64, 65};
    while (hash_cmds.size() < 300 || edge_lens.size() > 0) begin
      if (edge_lens.size() > 0 && $urandom_range(0, 1) == 0) begin
        queue_message(edge_lens.pop_front());
      end else if ($urandom_range(0, 19) == 0) begin
        queue_message($urandom_range(118, 120));
      end else begin
        queue_message(0);
        queue_message($urandom_range(0, 12));
      end
    end

    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    while (hash_cmds.size() > 0 || in_valid) @(posedge clk);
    while (expected_digest.size() > 0) @(posedge clk);
    repeat (100) @(posedge clk);
    if (err_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

  initial begin
    #(TIMEOUT_NS);
    $display("DONE: errors detected");
    $finish;
  end

endmodule
